// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the sorted insert priority queue.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `ASSERT_CLK(lbl, clk, rstn, !(cond), msg)
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

// File: hw/rtl/spiq_pkg.sv
// Types and constants of the sorted insert priority queue.
// No dependencies; imported by spiq_cell and the top level.
package spiq_pkg;

  localparam int unsigned DataW       = 32;
  localparam int unsigned PrioW       = 16;
  localparam int unsigned PosW        = 4;
  localparam int unsigned CapacityDef = 16;

  // One stored entry.
  typedef struct packed {
    logic signed [PrioW-1:0] prio;
    logic signed [DataW-1:0] data;
  } entry_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;  // place the new entry, shift the lower part down
    logic rotate;  // advance the occupied part one place towards the head
  } cell_cmd_t;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StList = 3'b010,
    StOvfl = 3'b100
  } state_e;

endpackage

// File: hw/rtl/sorted_insert_priority_queue.sv
// Sorted insert priority queue: an accepted insert is placed in the cell chain, then
// the whole store is listed head first through the output register, the chain rotating
// one place per word taken; a refused insert is answered with one overflow word.
// Reset (rst_ni low, asynchronous) clears the entry count, the state and the output valid;
// entry contents stay undefined until written and get no clearing pass.
`include "assert_macros.svh"

module sorted_insert_priority_queue import spiq_pkg::*; #(
  parameter int unsigned CAPACITY = CapacityDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // item_data [31:0], item_priority [47:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // out_data [31:0], out_priority [47:32],
                                      // out_position [51:48], zero [55:52]
  output logic        m_axis_tlast,   // is_last
  output logic        m_axis_tuser    // overflow
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = $clog2(CAPACITY);

  // Control state
  state_e           state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic             m_valid_q, m_valid_d;

  // Output register payload, no reset
  entry_t           out_q, out_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic             last_q, last_d;
  logic             ovf_q, ovf_d;

  // Chain
  entry_t           new_item;
  entry_t           cell_q [CAPACITY];
  logic             lt     [CAPACITY];
  cell_cmd_t        cmd;

  logic             s_accept;
  logic             out_free;
  logic             full;
  logic             at_last;

  assign new_item.data = s_axis_tdata[31:0];
  assign new_item.prio = s_axis_tdata[47:32];

  assign s_axis_tready = (state_q == StIdle);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  // Output register may take a new word when empty or being drained this cycle.
  assign out_free      = !m_valid_q || m_axis_tready;
  assign full          = (cnt_q == CntW'(CAPACITY));
  assign at_last       = (CntW'(idx_q) + CntW'(1)) == cnt_q;

  // Cell chain: insert shifts the whole lower part down one place at once;
  // listing rotates the occupied part so the head cell always shows the next word.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    logic   left_lt;

    if (g == 0) begin : g_head
      assign left_e  = new_item;
      assign left_lt = 1'b0;
    end else begin : g_body
      assign left_e  = cell_q[g-1];
      assign left_lt = lt[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign right_e = cell_q[0];
    end else begin : g_mid
      assign right_e = cell_q[g+1];
    end

    spiq_cell #(
      .CAPACITY (CAPACITY),
      .CELL_IDX (g)
    ) u_cell (
      .clk_i     (clk_i),
      .cmd_i     (cmd),
      .cnt_i     (cnt_q),
      .new_i     (new_item),
      .left_i    (left_e),
      .left_lt_i (left_lt),
      .right_i   (right_e),
      .head_i    (cell_q[0]),
      .entry_o   (cell_q[g]),
      .lt_o      (lt[g])
    );
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    out_d      = out_q;
    pos_d      = pos_q;
    last_d     = last_q;
    ovf_d      = ovf_q;
    cmd.insert = 1'b0;
    cmd.rotate = 1'b0;
    m_valid_d  = m_axis_tready ? 1'b0 : m_valid_q;

    case (state_q)
      StIdle: begin
        if (s_accept) begin
          if (full) begin
            // Refuse: leave the store alone, answer with one overflow word.
            state_d = StOvfl;
          end else begin
            cmd.insert = 1'b1;
            cnt_d      = cnt_q + CntW'(1);
            idx_d      = '0;
            state_d    = StList;
          end
        end
      end
      StList: begin
        if (out_free) begin
          out_d      = cell_q[0];
          pos_d      = PosW'(idx_q);
          last_d     = at_last;
          ovf_d      = 1'b0;
          m_valid_d  = 1'b1;
          cmd.rotate = 1'b1;
          if (at_last) begin
            state_d = StIdle;
          end else begin
            idx_d = idx_q + IdxW'(1);
          end
        end
      end
      StOvfl: begin
        if (out_free) begin
          out_d     = '0;
          pos_d     = '0;
          last_d    = 1'b1;
          ovf_d     = 1'b1;
          m_valid_d = 1'b1;
          state_d   = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cnt_q     <= '0;
      idx_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      idx_q     <= idx_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pos_q  <= pos_d;
    last_q <= last_d;
    ovf_q  <= ovf_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'b0000, pos_q, out_q.prio, out_q.data};
  assign m_axis_tlast  = last_q;
  assign m_axis_tuser  = ovf_q;

  // Checks
  `ASSERT_NEVER(a_cnt_bound, clk_i, rst_ni, cnt_q > CntW'(CAPACITY), "entry count above capacity")
  `ASSERT_CLK(a_ovf_last, clk_i, rst_ni, (m_valid_q && ovf_q) |-> last_q, "overflow word not last")
  `ASSERT_CLK(a_cnt_accept, clk_i, rst_ni, (cnt_q != $past(cnt_q)) |-> $past(s_accept), "count moved without accept")

  for (genvar k = 1; k < CAPACITY; k++) begin : g_chk
    `ASSERT_CLK(a_sorted, clk_i, rst_ni, (state_q == StIdle && CntW'(k) < cnt_q) |-> (cell_q[k-1].prio >= cell_q[k].prio), "chain out of order")
  end

endmodule

// File: hw/rtl/spiq_cell.sv
// One storage cell of the priority queue chain.
// Depends on spiq_pkg (entry_t, cell_cmd_t).
module spiq_cell import spiq_pkg::*; #(
  parameter int unsigned CAPACITY = CapacityDef,
  parameter int unsigned CELL_IDX = 0,
  localparam int unsigned CntW = $clog2(CAPACITY + 1)
) (
  input  logic            clk_i,
  input  cell_cmd_t       cmd_i,
  input  logic [CntW-1:0] cnt_i,
  input  entry_t          new_i,
  input  entry_t          left_i,
  input  logic            left_lt_i,
  input  entry_t          right_i,
  input  entry_t          head_i,
  output entry_t          entry_o,
  output logic            lt_o
);

  entry_t entry_q, entry_d;
  logic   occ;
  logic   last_occ;

  assign occ      = CntW'(CELL_IDX) < cnt_i;
  assign last_occ = (CntW'(CELL_IDX) + CntW'(1)) == cnt_i;
  // Empty cells count as lower, so the slot is the first lower or empty cell.
  assign lt_o     = !occ || (entry_q.prio < new_i.prio);

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.insert) begin
      if (left_lt_i) begin
        entry_d = left_i;
      end else if (lt_o) begin
        entry_d = new_i;
      end
    end else if (cmd_i.rotate && occ) begin
      entry_d = last_occ ? head_i : right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// File: bench/sorted_insert_priority_queue_test.sv
// Self-checking bench for sorted_insert_priority_queue: streams insert words in,
// predicts each listing and refusal, and compares every output word field by field.
// Depends on spiq_pkg and the RTL of the block only.
module sorted_insert_priority_queue_test import spiq_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QueueDepth = CapacityDef;
  localparam int unsigned TotalItems = 230;

  // Clock, reset and the driven side of both streams. Everything starts at a
  // known value so the block never sees an X on an input.
  logic                     clk_i     = 1'b0;
  logic                     rst_ni    = 1'b0;
  logic                     in_valid  = 1'b0;
  logic [PrioW+DataW-1:0]   in_word   = '0;   // item_data [31:0], item_priority [47:32]
  logic                     out_ready = 1'b0;

  logic                     s_axis_tready;
  logic                     m_axis_tvalid;
  logic [55:0]              m_axis_tdata;       // out_data [31:0], out_priority [47:32],
                                                // out_position [51:48], zero [55:52]
  logic                     m_axis_tlast;       // is_last
  logic                     m_axis_tuser;       // overflow

  sorted_insert_priority_queue #(
    .CAPACITY(QueueDepth)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(in_valid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (in_word),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(out_ready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  // One expected output word.
  typedef struct {
    logic [DataW-1:0] data;
    logic [PrioW-1:0] prio;
    logic [PosW-1:0]  pos;
    logic             last;
    logic             refused;
  } listing_word_t;

  // Shadow copy of the queue contents, kept in descending priority order.
  logic [DataW-1:0]        held_data [QueueDepth];
  logic signed [PrioW-1:0] held_prio [QueueDepth];
  int unsigned             held_count = 0;

  listing_word_t listing_q[$];   // words still owed by the block, oldest first
  int unsigned   mismatches = 0;
  int unsigned   items_sent = 0;
  bit            steady_pace = 1'b0;  // suppress all gaps on both sides while set

  initial begin : clock_gen
    forever #4 clk_i = ~clk_i;
  end

  initial begin : watchdog
    // Stop a hung run; the limit leaves a wide margin over the slowest correct run.
    #2_000_000;
    $display("sorted_insert_priority_queue_test: done, errors");
    $finish;
  end

  // Mostly back-to-back, sometimes a short pause, now and then a long one.
  function automatic int pick_gap();
    int roll;
    if (steady_pace) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Work out what one accepted insert produces and queue it up.
  function automatic void predict_insert(logic [DataW-1:0] d, logic signed [PrioW-1:0] p);
    listing_word_t w;
    int unsigned   slot;
    int unsigned   i;
    if (held_count >= QueueDepth) begin
      // Full: refuse, leave the store alone, answer with one flagged word.
      w.data    = '0;
      w.prio    = '0;
      w.pos     = '0;
      w.last    = 1'b1;
      w.refused = 1'b1;
      listing_q.push_back(w);
      return;
    end
    // Land ahead of the first strictly lower priority, so ties keep arrival order.
    slot = held_count;
    for (i = 0; i < held_count; i++) begin
      if (held_prio[i] < p) begin
        slot = i;
        break;
      end
    end
    for (i = held_count; i > slot; i--) begin
      held_data[i] = held_data[i-1];
      held_prio[i] = held_prio[i-1];
    end
    held_data[slot] = d;
    held_prio[slot] = p;
    held_count++;
    // List the whole store, head first, last word marked.
    for (i = 0; i < held_count; i++) begin
      w.data    = held_data[i];
      w.prio    = held_prio[i];
      w.pos     = i[PosW-1:0];
      w.last    = (i + 1 == held_count);
      w.refused = 1'b0;
      listing_q.push_back(w);
    end
  endfunction

  function automatic void flag_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
  endfunction

  // Offer one word and hold it until the block takes it. Valid is lowered only
  // when a gap precedes the word, so back-to-back words keep it high.
  task automatic send_item(input logic [DataW-1:0] d, input logic [PrioW-1:0] p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= {p, d};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_insert(d, p);
    items_sent++;
  endtask

  // Drop valid and hold off until every owed word has come out.
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (listing_q.size() != 0);
  endtask

  // Sink side: runs of ready broken by stalls of random length.
  initial begin : sink_pacing
    int run;
    int stall;
    forever begin
      run = $urandom_range(1, 24);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk_i);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  // Compare every word taken from the block with the oldest one owed.
  always @(posedge clk_i) begin : listing_check
    listing_word_t want;
    if (rst_ni && m_axis_tvalid && out_ready) begin
      if (listing_q.size() == 0) begin
        flag_mismatch("unexpected word", '0, {8'h0, m_axis_tdata});
      end else begin
        want = listing_q.pop_front();
        if (m_axis_tdata[31:0] !== want.data)
          flag_mismatch("out_data", 64'(want.data), 64'(m_axis_tdata[31:0]));
        if (m_axis_tdata[47:32] !== want.prio)
          flag_mismatch("out_priority", 64'(want.prio), 64'(m_axis_tdata[47:32]));
        if (m_axis_tdata[51:48] !== want.pos)
          flag_mismatch("out_position", 64'(want.pos), 64'(m_axis_tdata[51:48]));
        if (m_axis_tdata[55:52] !== 4'h0)
          flag_mismatch("tdata padding", '0, 64'(m_axis_tdata[55:52]));
        if (m_axis_tlast !== want.last)
          flag_mismatch("is_last", 64'(want.last), 64'(m_axis_tlast));
        if (m_axis_tuser !== want.refused)
          flag_mismatch("overflow", 64'(want.refused), 64'(m_axis_tuser));
      end
    end
  end

  // Top, bottom, zero and minus one: placement at head, tail and middle,
  // and signed ordering across the sign boundary.
  task automatic test_extreme_priorities();
    send_item(32'h7FFF_FFFF, 16'h0000);
    send_item(32'h8000_0000, 16'h7FFF);
    send_item(32'h0000_0000, 16'h8000);
    send_item(32'hFFFF_FFFF, 16'hFFFF);
  endtask

  // Equal priorities at head, middle and tail: the newcomer goes behind the
  // older entry. Run without gaps so the listings come out back to back.
  task automatic test_tie_order();
    steady_pace = 1'b1;
    send_item(32'hA5A5_A5A5, 16'h0000);
    send_item(32'h5A5A_5A5A, 16'h7FFF);
    send_item(32'h1234_5678, 16'h8000);
    send_item(32'h0F0F_0F0F, 16'h0001);
    steady_pace = 1'b0;
  endtask

  // Alternating bit patterns in both fields.
  task automatic test_bit_patterns();
    send_item(32'h5555_5555, 16'h5555);
    send_item(32'hAAAA_AAAA, 16'hAAAA);
  endtask

  // Fill the rest of the store with random words; a third of them reuse a held
  // priority so ties land at random places.
  task automatic test_random_fill();
    logic [PrioW-1:0] p;
    while (held_count < QueueDepth) begin
      if (held_count > 0 && $urandom_range(0, 2) == 0)
        p = held_prio[$urandom_range(0, held_count - 1)];
      else
        p = PrioW'($urandom_range(0, 16'hFFFF));
      send_item($urandom(), p);
    end
  endtask

  // Full store: extreme words must each be refused with one flagged word.
  task automatic test_full_refusal();
    send_item(32'h7FFF_FFFF, 16'h7FFF);
    send_item(32'h8000_0000, 16'h8000);
    send_item(32'h0000_0000, 16'h0000);
  endtask

  // Random words against the full store; pause once halfway to let it drain.
  task automatic test_random_refusal();
    int unsigned halfway;
    halfway = (items_sent + TotalItems) / 2;
    while (items_sent < TotalItems) begin
      if (items_sent == halfway) wait_drain();
      send_item($urandom(), PrioW'($urandom_range(0, 16'hFFFF)));
    end
  endtask

  initial begin : run_tests
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extreme_priorities();
    test_tie_order();
    wait_drain();
    test_bit_patterns();
    test_random_fill();
    wait_drain();
    test_full_refusal();
    test_random_refusal();

    // Hold until every listing is in, then wait on for stray words.
    wait_drain();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && listing_q.size() == 0)
      $display("sorted_insert_priority_queue_test: done, clean");
    else
      $display("sorted_insert_priority_queue_test: done, errors");
    $finish;
  end

endmodule
